FILE: rtl/tmr_pkg.sv
package tmr_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = 4;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 6;
  localparam int CFG_AW      = 3;
  localparam int RECIP_W     = 29;
  localparam int MS_SHIFT    = 38;

  localparam logic [DATA_W-1:0] TICK_RESET_US = 32'd1000;
  localparam logic [DATA_W-1:0] US_PER_MS     = 32'd1000;
  // ceil(2^38 / 1000), exact floor division by 1000 for any 32-bit value
  localparam logic [RECIP_W-1:0] MS_RECIP     = 29'd274877907;
  localparam logic [CNT_W-1:0]  DIV_STEPS     = 6'd32;

  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_REMOVE  = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;
  localparam logic [1:0] CMD_SERVICE = 2'd3;

  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [0:0] REG_TICK_PERIOD = 1'b0;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SLOT_W-1:0] slot;
    logic              oneshot;
    logic [DATA_W-1:0] delay_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot_out;
    logic              ok;
    logic              last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_TP,
    ST_DIV_DLY,
    ST_CREATE,
    ST_REMOVE,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_SRV_RD,
    ST_SRV_CHK,
    ST_SRV_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic div_tp;
    logic div_dly;
    logic idx_clr;
    logic idx_inc;
    logic create_wr;
    logic remove_do;
    logic tick_wr;
    logic srv_chk;
    logic srv_done;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic idx_last;
  } dp_sts_t;

endpackage

FILE: rtl/multi_slot_software_timer.sv
// per item: create scales the tick period by reciprocal multiplication, then runs a
// 32-step division of its delay before its beat; remove does no division; service walks
// all slots to done; tick gives no beat and holds busy while it rewrites all 16 counters
// throughput: one item at a time, busy high until its last beat or its tick walk is done
// the rate is set by the one-bit-per-cycle divider and the single counter ram read port
// reset: synchronous active-low rst_n clears slot flags and control, sets tick period (1000)
module multi_slot_software_timer import tmr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  // result channel, one-cycle strobes, the receiver cannot stall
  output logic              out_valid,
  output out_item_t         out_item,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DATA_W-1:0] tick_period_r;
  logic              cfg_wr;
  dp_cmd_t           dp_cmd;
  dp_sts_t           dp_sts;

  // register index is the word address; only the tick period exists
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_TICK_PERIOD);
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1] == REG_TICK_PERIOD) ? tick_period_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= TICK_RESET_US;
    end else if (cfg_wr) begin
      tick_period_r <= pwdata;
    end
  end

  // sequencer: one state per phase of create, remove, tick walk, service walk
  tmr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_item.cmd),
    .sts    (dp_sts),
    .busy   (busy),
    .cmd    (dp_cmd)
  );

  // slot table, counter and reload memories, divider, result register
  tmr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .tick_period (tick_period_r),
    .cmd         (dp_cmd),
    .sts         (dp_sts),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

  // a new item only starts from an accepted command
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // the final beat of an item is issued as the block goes idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy)
    else $error("last beat while still busy");

  // expiry events only appear inside a running service walk
  a_expiry_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy && (out_item.kind == KIND_EXPIRY))
    else $error("stray non-final beat");

endmodule

FILE: rtl/tmr_ram.sv
module tmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tmr_ctrl.sv
module tmr_ctrl import tmr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_cmd,
  input  dp_sts_t    sts,
  output logic       busy,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_cmd)
            CMD_CREATE: state_nxt = ST_DIV_TP;
            CMD_REMOVE: state_nxt = ST_REMOVE;
            CMD_TICK:   state_nxt = ST_TICK_RD;
            default:    state_nxt = ST_SRV_RD;
          endcase
        end
      end
      ST_DIV_TP:   state_nxt = ST_DIV_DLY;
      ST_DIV_DLY:  if (sts.div_done) state_nxt = ST_CREATE;
      ST_CREATE:   state_nxt = ST_IDLE;
      ST_REMOVE:   state_nxt = ST_IDLE;
      ST_TICK_RD:  state_nxt = ST_TICK_WR;
      ST_TICK_WR:  state_nxt = sts.idx_last ? ST_IDLE : ST_TICK_RD;
      ST_SRV_RD:   state_nxt = ST_SRV_CHK;
      ST_SRV_CHK:  state_nxt = sts.idx_last ? ST_SRV_DONE : ST_SRV_RD;
      ST_SRV_DONE: state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.latch   = accept;
    cmd.idx_clr = accept;
    cmd.div_tp  = accept && (in_cmd == CMD_CREATE);
    case (state_r)
      ST_DIV_TP:   cmd.div_dly   = 1'b1;
      ST_CREATE:   cmd.create_wr = 1'b1;
      ST_REMOVE:   cmd.remove_do = 1'b1;
      ST_TICK_WR: begin
        cmd.tick_wr = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      ST_SRV_CHK: begin
        cmd.srv_chk = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      ST_SRV_DONE: cmd.srv_done = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/tmr_dp.sv
module tmr_dp import tmr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_item,
  input  logic [DATA_W-1:0] tick_period,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  output logic              out_valid,
  output out_item_t         out_item
);

  in_item_t                 item_r;
  logic [TIMER_SLOTS-1:0]   active_r, active_nxt;
  logic [TIMER_SLOTS-1:0]   oneshot_r, oneshot_nxt;
  logic [SLOT_W-1:0]        idx_r;

  // tick period in whole milliseconds by reciprocal multiplication
  logic [DATA_W+RECIP_W-1:0] tp_prod;
  logic [DATA_W-1:0]         tp_ms, tp_ms_r;

  // shift-subtract divider, one quotient bit a cycle
  logic [DATA_W-1:0]        rem_r, quo_r, dsr_r;
  logic [CNT_W-1:0]         dcnt_r;
  logic [DATA_W:0]          shifted, diff;
  logic                     fits;

  logic [DATA_W-1:0]        cnt_rd, rld_rd;
  logic                     cnt_we;
  logic [SLOT_W-1:0]        cnt_waddr;
  logic [DATA_W-1:0]        cnt_wdata;
  logic                     inrange, hit;

  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  assign inrange = ({1'b0, item_r.slot} < (SLOT_W+1)'(TIMER_SLOTS));
  assign hit     = active_r[idx_r] && (cnt_rd == '0);

  assign tp_prod = {{RECIP_W{1'b0}}, tick_period} * {{DATA_W{1'b0}}, MS_RECIP};
  assign tp_ms   = DATA_W'(tp_prod[DATA_W+RECIP_W-1:MS_SHIFT]);

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign fits    = !diff[DATA_W];

  assign sts.div_done = (dcnt_r == '0);
  assign sts.idx_last = (idx_r == SLOT_W'(TIMER_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
    end
    if (cmd.div_tp) begin
      tp_ms_r <= tp_ms;
    end
    if (cmd.div_dly) begin
      // divisor clamped to one for a tick below a millisecond
      rem_r <= '0;
      quo_r <= item_r.delay_ms;
      dsr_r <= (tp_ms_r == '0) ? DATA_W'(1) : tp_ms_r;
    end else if (dcnt_r != '0) begin
      rem_r <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r      <= '0;
      idx_r       <= '0;
      active_r    <= '0;
      oneshot_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.div_dly) begin
        dcnt_r <= DIV_STEPS;
      end else if (dcnt_r != '0) begin
        dcnt_r <= dcnt_r - CNT_W'(1);
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + SLOT_W'(1);
      end
      active_r    <= active_nxt;
      oneshot_r   <= oneshot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // slot flags
  always_comb begin
    active_nxt  = active_r;
    oneshot_nxt = oneshot_r;
    if (cmd.create_wr && inrange) begin
      active_nxt[item_r.slot]  = 1'b1;
      oneshot_nxt[item_r.slot] = item_r.oneshot;
    end
    if (cmd.remove_do && inrange) begin
      active_nxt[item_r.slot] = 1'b0;
    end
    if (cmd.srv_chk && hit && oneshot_r[idx_r]) begin
      active_nxt[idx_r] = 1'b0;
    end
  end

  // counter memory write port
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx_r;
    cnt_wdata = rld_rd;
    if (cmd.create_wr) begin
      cnt_we    = inrange;
      cnt_waddr = item_r.slot;
      cnt_wdata = quo_r;
    end else if (cmd.tick_wr) begin
      cnt_we    = active_r[idx_r] && (cnt_rd != '0);
      cnt_wdata = cnt_rd - DATA_W'(1);
    end else if (cmd.srv_chk) begin
      cnt_we    = hit;
    end
  end

  // result beat
  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    if (cmd.create_wr) begin
      out_valid_nxt    = 1'b1;
      out_nxt.kind     = KIND_CREATE;
      out_nxt.slot_out = item_r.slot;
      out_nxt.ok       = inrange;
      out_nxt.last     = 1'b1;
    end else if (cmd.remove_do) begin
      out_valid_nxt    = 1'b1;
      out_nxt.kind     = KIND_REMOVE;
      out_nxt.slot_out = item_r.slot;
      out_nxt.ok       = inrange && active_r[item_r.slot];
      out_nxt.last     = 1'b1;
    end else if (cmd.srv_chk && hit) begin
      out_valid_nxt    = 1'b1;
      out_nxt.kind     = KIND_EXPIRY;
      out_nxt.slot_out = idx_r;
    end else if (cmd.srv_done) begin
      out_valid_nxt    = 1'b1;
      out_nxt.kind     = KIND_DONE;
      out_nxt.last     = 1'b1;
    end
  end

  tmr_ram #(.WIDTH(DATA_W), .DEPTH(TIMER_SLOTS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (idx_r),
    .rdata (cnt_rd)
  );

  tmr_ram #(.WIDTH(DATA_W), .DEPTH(TIMER_SLOTS)) u_rld_ram (
    .clk   (clk),
    .we    (cmd.create_wr && inrange),
    .waddr (item_r.slot),
    .wdata (quo_r),
    .raddr (idx_r),
    .rdata (rld_rd)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: tb/sv/tb_multi_slot_software_timer.sv
`timescale 1ns / 1ps

module tb_multi_slot_software_timer;
  import tmr_pkg::*;

  // cycles with no accepted beat on either side before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  // settle time after the last result, covers a tick pass that gives no result
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASES = 7;
  localparam int RANDOM_PER_PHASE = 62;
  localparam logic [CFG_AW-1:0] TICK_ADDR = {REG_TICK_PERIOD, 2'b00};

  typedef struct packed {
    logic     drain;  // wait for every outstanding result before sending
    in_item_t item;
  } cmd_slot_t;

  logic clk;
  logic rst_n = 1'b0;

  logic              start = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  multi_slot_software_timer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // timer table as the block should hold it
  logic              slot_on    [TIMER_SLOTS];
  logic              slot_once  [TIMER_SLOTS];
  logic [DATA_W-1:0] slot_reload[TIMER_SLOTS];
  logic [DATA_W-1:0] slot_count [TIMER_SLOTS];
  logic [DATA_W-1:0] tick_us;

  out_item_t expected_beats[$];
  cmd_slot_t pending_cmds[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        gap_left = 0;
  int        calm_left = 0;
  logic      item_taken = 1'b0;

  // work out the result beats one accepted command causes
  function automatic void predict_timer(in_item_t it);
    logic [DATA_W-1:0] div;
    out_item_t         r;
    div = tick_us / US_PER_MS;
    // a tick period under one millisecond clamps the divisor to one
    if (div == '0) div = 1;
    case (it.cmd)
      CMD_CREATE: begin
        // overwrites an active slot, the ack is still ok
        slot_on[it.slot]     = 1'b1;
        slot_once[it.slot]   = it.oneshot;
        slot_reload[it.slot] = it.delay_ms / div;
        slot_count[it.slot]  = it.delay_ms / div;
        r = '{kind: KIND_CREATE, slot_out: it.slot, ok: 1'b1, last: 1'b1};
        expected_beats.push_back(r);
      end
      CMD_REMOVE: begin
        // ok tells whether the slot was active
        r = '{kind: KIND_REMOVE, slot_out: it.slot, ok: slot_on[it.slot], last: 1'b1};
        slot_on[it.slot] = 1'b0;
        expected_beats.push_back(r);
      end
      CMD_TICK: begin
        // counters stop at zero, no result beat
        for (int i = 0; i < TIMER_SLOTS; i++)
          if (slot_on[i] && slot_count[i] != '0) slot_count[i] = slot_count[i] - 1;
      end
      default: begin
        // expiries in ascending slot order, then the closing done beat
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (slot_on[i] && slot_count[i] == '0) begin
            r = '{kind: KIND_EXPIRY, slot_out: SLOT_W'(i), ok: 1'b0, last: 1'b0};
            expected_beats.push_back(r);
            slot_count[i] = slot_reload[i];
            if (slot_once[i]) slot_on[i] = 1'b0;
          end
        end
        r = '{kind: KIND_DONE, slot_out: '0, ok: 1'b0, last: 1'b1};
        expected_beats.push_back(r);
      end
    endcase
  endfunction

  // mostly short gaps, some long, and now and then a stretch with none
  function automatic int pick_gap();
    int r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm_left = $urandom_range(10, 40);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 80);
    return $urandom_range(100, 300);
  endfunction

  // command driver, changes inputs on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // beat still offered, hold it
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_cmds.size() != 0 &&
                 !(pending_cmds[0].drain && (expected_beats.size() != 0 || busy))) begin
      in_item  <= pending_cmds[0].item;
      start    <= 1'b1;
      gap_left <= pick_gap();
      void'(pending_cmds.pop_front());
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: command acceptance feeds the predictor, result beats are checked
  always @(posedge clk) begin
    out_item_t want;
    item_taken <= start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: kind %0d slot %0d ok %0d last %0d",
                     out_item.kind, out_item.slot_out, out_item.ok, out_item.last);
        end else begin
          want = expected_beats.pop_front();
          if (out_item.kind !== want.kind || out_item.slot_out !== want.slot_out ||
              out_item.ok !== want.ok || out_item.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected kind %0d slot %0d ok %0d last %0d, ",
                        "got kind %0d slot %0d ok %0d last %0d"},
                       want.kind, want.slot_out, want.ok, want.last,
                       out_item.kind, out_item.slot_out, out_item.ok, out_item.last);
          end
        end
      end
      if (start && !busy) predict_timer(in_item);
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic queue_cmd(logic [1:0] cmd, logic [SLOT_W-1:0] slot, logic os,
                           logic [DATA_W-1:0] dly, logic hold, inout int count);
    cmd_slot_t c;
    c.item.cmd      = cmd;
    c.item.slot     = slot;
    c.item.oneshot  = os;
    c.item.delay_ms = dly;
    c.drain         = hold || ($urandom_range(0, 29) == 0);
    pending_cmds.push_back(c);
    count++;
  endtask

  // delays that land on a few ticks, with zero and full-range ones mixed in
  function automatic logic [DATA_W-1:0] pick_delay(logic [DATA_W-1:0] div);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return $urandom;
    return $urandom_range(0, 5) * div + $urandom_range(0, div - 1);
  endfunction

  // one apb transfer to the tick period register
  task automatic cfg_access(logic wr, logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TICK_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // block quiet: nothing queued or offered, nothing outstanding, then settle
  task automatic wait_quiet();
    do @(posedge clk);
    while (!(pending_cmds.size() == 0 && !start && expected_beats.size() == 0 && !busy));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [DATA_W-1:0] periods[PHASES];
    logic [DATA_W-1:0] div;
    logic [DATA_W-1:0] rd;
    int                n;
    int                k;

    for (int i = 0; i < TIMER_SLOTS; i++) begin
      slot_on[i]     = 1'b0;
      slot_once[i]   = 1'b0;
      slot_reload[i] = '0;
      slot_count[i]  = '0;
    end
    tick_us = TICK_RESET_US;

    // reset default first, then zero, full range, just under a millisecond and others
    periods = '{TICK_RESET_US, 32'd0, 32'hFFFF_FFFF, 32'd999, 32'd3000,
                $urandom_range(1000, 20000), 32'd1000};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      n = 0;
      if (p != 0) begin
        cfg_access(1'b1, periods[p], rd);
        tick_us = periods[p];
        cfg_access(1'b0, '0, rd);
        if (rd !== periods[p]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tick period readback: expected %0d got %0d", periods[p], rd);
        end
      end
      div = tick_us / US_PER_MS;
      if (div == '0) div = 1;

      if (p == 0) begin
        // zero delay one-shot fires once and is freed
        queue_cmd(CMD_CREATE, 4'd0, 1'b1, 32'd0, 1'b0, n);
        queue_cmd(CMD_CREATE, 4'd15, 1'b0, 32'd2, 1'b0, n);
        queue_cmd(CMD_CREATE, 4'd5, 1'b0, 32'hFFFF_FFFF, 1'b0, n);
        queue_cmd(CMD_SERVICE, 4'd0, 1'b0, 32'd0, 1'b0, n);
        queue_cmd(CMD_SERVICE, 4'd0, 1'b0, 32'd0, 1'b1, n);
        queue_cmd(CMD_TICK, 4'd0, 1'b0, 32'd0, 1'b0, n);
        queue_cmd(CMD_TICK, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b0, n);
        queue_cmd(CMD_SERVICE, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b0, n);
        // create over an active periodic slot
        queue_cmd(CMD_CREATE, 4'd15, 1'b1, 32'd1, 1'b0, n);
        queue_cmd(CMD_TICK, 4'd0, 1'b0, 32'd0, 1'b0, n);
        queue_cmd(CMD_SERVICE, 4'd0, 1'b0, 32'd0, 1'b0, n);
        // remove of a freed slot, an active one, and a never used one
        queue_cmd(CMD_REMOVE, 4'd15, 1'b0, 32'd0, 1'b0, n);
        queue_cmd(CMD_REMOVE, 4'd5, 1'b0, 32'd0, 1'b0, n);
        queue_cmd(CMD_REMOVE, 4'd5, 1'b1, 32'hFFFF_FFFF, 1'b0, n);
        queue_cmd(CMD_REMOVE, 4'd9, 1'b0, 32'd0, 1'b0, n);
        // periodic zero delay expires at every service
        queue_cmd(CMD_CREATE, 4'd3, 1'b0, 32'd0, 1'b0, n);
        queue_cmd(CMD_SERVICE, 4'd0, 1'b0, 32'd0, 1'b0, n);
        queue_cmd(CMD_SERVICE, 4'd0, 1'b0, 32'd0, 1'b0, n);
        queue_cmd(CMD_CREATE, 4'd10, 1'b1, 32'h5555_5555, 1'b0, n);
        queue_cmd(CMD_CREATE, 4'd6, 1'b0, 32'hAAAA_AAAA, 1'b0, n);
        queue_cmd(CMD_REMOVE, 4'd3, 1'b0, 32'd0, 1'b0, n);
        queue_cmd(CMD_REMOVE, 4'd10, 1'b0, 32'd0, 1'b0, n);
        queue_cmd(CMD_REMOVE, 4'd6, 1'b0, 32'd0, 1'b0, n);
        queue_cmd(CMD_SERVICE, 4'd12, 1'b1, 32'h1234_5678, 1'b0, n);
        n = 0;
      end

      while (n < RANDOM_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // lone command with random content, unused fields random too
            k = $urandom_range(0, 9);
            if (k < 3)
              queue_cmd(CMD_CREATE, SLOT_W'($urandom), 1'($urandom), pick_delay(div),
                        1'b0, n);
            else if (k < 5)
              queue_cmd(CMD_REMOVE, SLOT_W'($urandom), 1'($urandom), $urandom, 1'b0, n);
            else if (k < 8)
              queue_cmd(CMD_TICK, SLOT_W'($urandom), 1'($urandom), $urandom, 1'b0, n);
            else
              queue_cmd(CMD_SERVICE, SLOT_W'($urandom), 1'($urandom), $urandom, 1'b0, n);
          end
          4, 5, 6, 7: begin
            // arm a few slots, let them run down, then service
            k = $urandom_range(1, 4);
            repeat (k)
              queue_cmd(CMD_CREATE, SLOT_W'($urandom), 1'($urandom), pick_delay(div),
                        1'b0, n);
            k = $urandom_range(0, 6);
            repeat (k)
              queue_cmd(CMD_TICK, SLOT_W'($urandom), 1'($urandom), $urandom, 1'b0, n);
            queue_cmd(CMD_SERVICE, SLOT_W'($urandom), 1'($urandom), $urandom, 1'b0, n);
            if ($urandom_range(0, 1))
              queue_cmd(CMD_SERVICE, SLOT_W'($urandom), 1'($urandom), $urandom, 1'b0, n);
          end
          8: begin
            // whole table armed, service can give every expiry at once
            for (int s = 0; s < TIMER_SLOTS; s++)
              queue_cmd(CMD_CREATE, SLOT_W'(s), 1'($urandom),
                        $urandom_range(0, 1) * div, 1'b0, n);
            queue_cmd(CMD_TICK, SLOT_W'($urandom), 1'($urandom), $urandom, 1'b0, n);
            queue_cmd(CMD_SERVICE, SLOT_W'($urandom), 1'($urandom), $urandom, 1'b0, n);
          end
          default: begin
            k = $urandom_range(1, 3);
            repeat (k)
              queue_cmd(CMD_REMOVE, SLOT_W'($urandom), 1'($urandom), $urandom, 1'b0, n);
          end
        endcase
      end
      wait_quiet();
    end

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tmr_pkg.sv
rtl/tmr_ram.sv
rtl/tmr_ctrl.sv
rtl/tmr_dp.sv
rtl/multi_slot_software_timer.sv
tb/sv/tb_multi_slot_software_timer.sv
